@@ rtl/core/reply_line_matcher_assert.svh @@
// assertion macros for the blocks that check themselves
`ifndef REPLY_LINE_MATCHER_ASSERT_SVH
`define REPLY_LINE_MATCHER_ASSERT_SVH

// condition holds whenever out of reset
`define RLM_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// cause on one edge implies effect on the next
`define RLM_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

@@ rtl/core/rlm_pkg.sv @@
`default_nettype none

package rlm_pkg;

    localparam int LINE_CHARS = 64;
    localparam int CNT_W      = $clog2(LINE_CHARS);

    localparam logic [7:0] LINE_END   = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [2:0]  TOK_MAX    = 3'd7;
    localparam logic [2:0]  TOK_TARGET = 3'd4;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_START   = 2'd1,
        ACT_TIMEOUT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MODE_ECHO   = 2'd0,
        MODE_LAST   = 2'd1,
        MODE_FOURTH = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_MATCH      = 2'd0,
        ST_MISMATCH   = 2'd1,
        ST_NO_REPLY   = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX_LOW  = 2'd0,
        CFG_PREFIX_HIGH = 2'd1,
        CFG_COMPARE_LEN = 2'd2,
        CFG_REPLY_MODE  = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic        negative;
        logic [31:0] acc;
    } t_num;

    localparam t_num NUM_CLEAR = '{phase: PH_SKIP, negative: 1'b0, acc: 32'd0};

    typedef struct packed {
        logic [63:0] prefix_low;
        logic [63:0] prefix_high;
        logic [4:0]  compare_len;
        logic [1:0]  reply_mode;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_line_res;

    function automatic logic [7:0] prefix_char(input logic [63:0] low,
                                               input logic [63:0] high,
                                               input logic [4:0]  idx);
        logic [127:0] all;
        all = {high, low};
        if (idx[4]) begin
            return 8'd0;
        end
        return all[{idx[3:0], 3'b000} +: 8];
    endfunction

    function automatic logic [31:0] num_value(input t_num n);
        if (n.negative) begin
            return 32'd0 - n.acc;
        end
        return n.acc[31] ? POS_MAX : n.acc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rlm_cfg.sv @@
`default_nettype none

module rlm_cfg
    import rlm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PREFIX_LOW:  r_cfg.prefix_low  <= i_cfg_data;
                CFG_PREFIX_HIGH: r_cfg.prefix_high <= i_cfg_data;
                CFG_COMPARE_LEN: r_cfg.compare_len <= i_cfg_data[4:0];
                CFG_REPLY_MODE:  r_cfg.reply_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/rlm_num_step.sv @@
`default_nettype none

module rlm_num_step
    import rlm_pkg::*;
(
    input  t_num              i_cur,
    input  wire logic [7:0]   i_byte,
    output t_num              o_fed,
    output logic [31:0]       o_fed_value
);

    logic        digit;
    logic        blank;
    logic [35:0] prod;

    assign digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign blank = (i_byte == CHAR_SPACE) || ((i_byte >= CHAR_TAB) && (i_byte <= CHAR_CR));
    assign prod  = ({4'd0, i_cur.acc} << 3) + ({4'd0, i_cur.acc} << 1)
                 + {32'd0, i_byte[3:0]};

    always_comb begin
        o_fed = i_cur;
        if (i_cur.phase == PH_DONE) begin
            o_fed = i_cur;
        end else if (digit) begin
            o_fed.acc   = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
            o_fed.phase = PH_DIGITS;
        end else if (i_cur.phase == PH_SKIP && blank) begin
            o_fed = i_cur;
        end else if (i_cur.phase == PH_SKIP &&
                     (i_byte == CHAR_PLUS || i_byte == CHAR_MINUS)) begin
            o_fed.negative = (i_byte == CHAR_MINUS);
            o_fed.phase    = PH_SIGN;
        end else begin
            o_fed.phase = PH_DONE;
        end
    end

    assign o_fed_value = num_value(o_fed);

endmodule

`default_nettype wire

@@ rtl/core/rlm_line.sv @@
`default_nettype none

module rlm_line
    import rlm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_line_res o_res
);

    logic             r_armed,    n_armed;
    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic             r_pfx_ok,   n_pfx_ok;
    logic             r_str_end,  n_str_end;
    logic [2:0]       r_tok,      n_tok;
    logic             r_in_tok,   n_in_tok;
    t_num             r_num,      n_num;
    logic             r_saw_sp,   n_saw_sp;
    logic [31:0]      r_fourth,   n_fourth;

    logic [7:0]  b;
    logic [7:0]  cnt_ext;
    logic        in_cmp;
    logic [7:0]  pfx;
    logic        line_end;
    logic [2:0]  tok_inc;
    logic        tok_start;
    t_num        feed_base;
    t_num        fed;
    logic [31:0] fed_value;
    logic        ok;
    logic [31:0] v;
    t_mode       mode;

    assign b        = i_item.rx_byte;
    assign mode     = t_mode'(i_cfg.reply_mode);
    assign cnt_ext  = 8'(r_cnt);
    assign in_cmp   = cnt_ext < {3'd0, i_cfg.compare_len};
    assign pfx      = prefix_char(i_cfg.prefix_low, i_cfg.prefix_high, cnt_ext[4:0]);
    assign line_end = (b == LINE_END) || (r_cnt >= CNT_W'(LINE_CHARS - 1));
    assign tok_inc  = (r_tok < TOK_MAX) ? r_tok + 3'd1 : r_tok;
    assign tok_start = (mode == MODE_FOURTH) && !r_in_tok && (tok_inc == TOK_TARGET);
    assign feed_base = tok_start ? NUM_CLEAR : r_num;

    rlm_num_step u_num_step (
        .i_cur       (feed_base),
        .i_byte      (b),
        .o_fed       (fed),
        .o_fed_value (fed_value)
    );

    always_comb begin
        n_armed   = r_armed;
        n_cnt     = r_cnt;
        n_pfx_ok  = r_pfx_ok;
        n_str_end = r_str_end;
        n_tok     = r_tok;
        n_in_tok  = r_in_tok;
        n_num     = r_num;
        n_saw_sp  = r_saw_sp;
        n_fourth  = r_fourth;
        o_res     = '0;
        ok        = r_pfx_ok;
        v         = 32'd0;

        case (t_action'(i_item.action))
            ACT_START: begin
                n_armed = 1'b1;
            end
            ACT_TIMEOUT: begin
                if (r_armed) begin
                    o_res.valid       = 1'b1;
                    o_res.item.status = (r_cnt == '0) ? ST_NO_REPLY : ST_INCOMPLETE;
                    n_armed           = 1'b0;
                end
            end
            ACT_BYTE: begin
                if (r_armed && !line_end) begin
                    if (r_pfx_ok && !r_str_end && in_cmp && pfx != b) begin
                        n_pfx_ok = 1'b0;
                    end
                    if (!r_str_end) begin
                        if (b == CHAR_NUL) begin
                            n_str_end = 1'b1;
                        end else begin
                            case (mode)
                                MODE_LAST: begin
                                    if (b == CHAR_SPACE) begin
                                        n_saw_sp = 1'b1;
                                        n_num    = NUM_CLEAR;
                                    end else begin
                                        n_num = fed;
                                    end
                                end
                                MODE_FOURTH: begin
                                    if (b == CHAR_SPACE) begin
                                        n_in_tok = 1'b0;
                                    end else begin
                                        if (!r_in_tok) begin
                                            n_in_tok = 1'b1;
                                            n_tok    = tok_inc;
                                        end
                                        if (tok_start) begin
                                            n_num = NUM_CLEAR;
                                        end
                                        if (n_tok == TOK_TARGET) begin
                                            n_num    = fed;
                                            n_fourth = fed_value;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    n_cnt = CNT_W'(r_cnt + 1'b1);
                end else if (r_armed) begin
                    if (r_pfx_ok && !r_str_end && in_cmp && pfx != CHAR_NUL) begin
                        ok = 1'b0;
                    end
                    if (ok && mode == MODE_LAST && r_saw_sp) begin
                        v = num_value(r_num);
                    end else if (ok && mode == MODE_FOURTH && r_tok >= TOK_TARGET) begin
                        v = r_fourth;
                    end
                    o_res.valid       = 1'b1;
                    o_res.item.status = ok ? ST_MATCH : ST_MISMATCH;
                    o_res.item.value  = v;
                    n_armed           = 1'b0;
                end
            end
            default: ;
        endcase

        // start and any result leave a fresh line behind
        if ((t_action'(i_item.action) == ACT_START) || o_res.valid) begin
            n_cnt     = '0;
            n_pfx_ok  = 1'b1;
            n_str_end = 1'b0;
            n_tok     = 3'd0;
            n_in_tok  = 1'b0;
            n_num     = NUM_CLEAR;
            n_saw_sp  = 1'b0;
            n_fourth  = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_cnt     <= '0;
            r_pfx_ok  <= 1'b1;
            r_str_end <= 1'b0;
            r_tok     <= 3'd0;
            r_in_tok  <= 1'b0;
            r_num     <= NUM_CLEAR;
            r_saw_sp  <= 1'b0;
            r_fourth  <= 32'd0;
        end else if (i_fire) begin
            r_armed   <= n_armed;
            r_cnt     <= n_cnt;
            r_pfx_ok  <= n_pfx_ok;
            r_str_end <= n_str_end;
            r_tok     <= n_tok;
            r_in_tok  <= n_in_tok;
            r_num     <= n_num;
            r_saw_sp  <= n_saw_sp;
            r_fourth  <= n_fourth;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/reply_line_matcher.sv @@
// reply line matcher
//
// input channel: one item per reply byte, or a start / timeout action,
// moved on i_in_valid with o_in_stall low. a start arms the block and
// clears the line; bytes build up the line until the terminator or until
// the line buffer length is reached, then one result item gives the prefix
// status and, depending on the reply mode, a parsed signed decimal value.
// a timeout while armed gives a no-reply or incomplete status.
// output channel: result items on o_out_valid, taken when i_out_stall is low.
// configuration: prefix, compare length and reply mode are written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only while
// no item is in flight; the block does not enforce this. an accepted item
// waits in the input register until it fires, and its result, if any, is
// then registered in the output register. throughput: one item per cycle
// while the output is not blocked; a stalled output holds its item, and the
// input register then fills and raises o_in_stall. reset clears all line
// state, the valid flags and the configuration and leaves the block idle.

`default_nettype none

module reply_line_matcher
    import rlm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_blocked;
    logic      fire;
    logic      accept;
    t_cfg      cfg;
    t_line_res res;

    assign out_blocked = r_out_valid && i_out_stall;
    assign fire        = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign accept      = i_in_valid && !o_in_stall;

    rlm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rlm_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out_item <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`include "reply_line_matcher_assert.svh"

    `RLM_ASSERT_NEXT(a_held_item_kept, r_in_valid && out_blocked,
        r_in_valid && $stable(r_in_item), "held input item lost")

    `RLM_ASSERT_HOLD(a_timeout_value_zero,
        !r_out_valid || (r_out_item.status != ST_NO_REPLY &&
        r_out_item.status != ST_INCOMPLETE && r_out_item.status != ST_MISMATCH) ||
        r_out_item.value == 32'sd0, "nonzero value with failing status")

    `RLM_ASSERT_NEXT(a_no_result_on_start,
        fire && !out_blocked && !r_out_valid &&
        r_in_item.action == ACT_START, !r_out_valid, "start produced a result")

endmodule

`default_nettype wire

@@ test/tb_reply_line_matcher.sv @@
`default_nettype none

module tb_reply_line_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import rlm_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // expected reply lines, worked out item by item
    class line_scoreboard;
        localparam logic [7:0] BLANK_LAST = 8'd13;

        t_cfg        cfg;
        bit          armed;
        int          char_count;
        bit          prefix_ok;
        bit          string_ended;
        int          token_number;
        bit          in_token;
        t_phase      phase;
        bit          negative;
        logic [31:0] magnitude;
        bit          saw_space;
        logic [31:0] fourth_value;
        t_out_item   expected_replies[$];
        int          errors;

        function new();
            cfg = '0;
            armed = 1'b0;
            errors = 0;
            clear_line();
        endfunction

        function void restart_number();
            phase = PH_SKIP;
            negative = 1'b0;
            magnitude = '0;
        endfunction

        function void clear_line();
            char_count = 0;
            prefix_ok = 1'b1;
            string_ended = 1'b0;
            token_number = 0;
            in_token = 1'b0;
            restart_number();
            saw_space = 1'b0;
            fourth_value = '0;
        endfunction

        function logic [7:0] expected_char(int idx);
            if (idx < 8) begin
                return cfg.prefix_low[idx*8 +: 8];
            end
            if (idx < 16) begin
                return cfg.prefix_high[(idx-8)*8 +: 8];
            end
            return CHAR_NUL;
        endfunction

        function logic [31:0] number_value();
            if (negative) begin
                return 32'd0 - magnitude;
            end
            return (magnitude > POS_MAX) ? POS_MAX : magnitude;
        endfunction

        function void feed_number(logic [7:0] b);
            logic [63:0] wide;
            if (phase == PH_DONE) begin
                return;
            end
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                wide = 64'(magnitude) * 64'd10 + 64'(b - CHAR_ZERO);
                if (wide > 64'(MAG_LIMIT)) begin
                    wide = 64'(MAG_LIMIT);
                end
                magnitude = wide[31:0];
                phase = PH_DIGITS;
            end else if (phase == PH_SKIP &&
                         (b == CHAR_SPACE || (b >= CHAR_TAB && b <= BLANK_LAST))) begin
                phase = PH_SKIP;
            end else if (phase == PH_SKIP && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
                negative = (b == CHAR_MINUS);
                phase = PH_SIGN;
            end else begin
                phase = PH_DONE;
            end
        endfunction

        function void add_reply(t_status st, logic [31:0] v);
            t_out_item want;
            want.status = st;
            want.value = v;
            expected_replies.push_back(want);
        endfunction

        function void take_item(t_in_item word);
            logic [7:0]  b;
            bit          ok;
            logic [31:0] v;
            b = word.rx_byte;
            if (word.action == ACT_START) begin
                armed = 1'b1;
                clear_line();
                return;
            end
            if (word.action == ACT_TIMEOUT) begin
                if (!armed) begin
                    return;
                end
                add_reply((char_count == 0) ? ST_NO_REPLY : ST_INCOMPLETE, 32'd0);
                armed = 1'b0;
                clear_line();
                return;
            end
            if (word.action != ACT_BYTE || !armed) begin
                return;
            end
            if (b != LINE_END && char_count < LINE_CHARS - 1) begin
                if (prefix_ok && !string_ended && char_count < cfg.compare_len &&
                    expected_char(char_count) != b) begin
                    prefix_ok = 1'b0;
                end
                if (!string_ended) begin
                    if (b == CHAR_NUL) begin
                        string_ended = 1'b1;
                    end else if (cfg.reply_mode == MODE_LAST) begin
                        if (b == CHAR_SPACE) begin
                            saw_space = 1'b1;
                            restart_number();
                        end else begin
                            feed_number(b);
                        end
                    end else if (cfg.reply_mode == MODE_FOURTH) begin
                        if (b == CHAR_SPACE) begin
                            in_token = 1'b0;
                        end else begin
                            if (!in_token) begin
                                in_token = 1'b1;
                                if (token_number < TOK_MAX) begin
                                    token_number++;
                                end
                                if (token_number == TOK_TARGET) begin
                                    restart_number();
                                end
                            end
                            if (token_number == TOK_TARGET) begin
                                feed_number(b);
                                fourth_value = number_value();
                            end
                        end
                    end
                end
                char_count = (char_count + 1) & 127;
                return;
            end
            // line end
            ok = prefix_ok;
            v = '0;
            if (ok && !string_ended && char_count < cfg.compare_len &&
                expected_char(char_count) != CHAR_NUL) begin
                ok = 1'b0;
            end
            if (ok && cfg.reply_mode == MODE_LAST && saw_space) begin
                v = number_value();
            end else if (ok && cfg.reply_mode == MODE_FOURTH && token_number >= TOK_TARGET) begin
                v = fourth_value;
            end
            add_reply(ok ? ST_MATCH : ST_MISMATCH, v);
            armed = 1'b0;
            clear_line();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_reply(t_out_item got);
            t_out_item want;
            if (expected_replies.size() == 0) begin
                report($sformatf("reply with nothing pending: status %0d value %0d",
                                 got.status, got.value));
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status) begin
                report($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.value !== want.value) begin
                report($sformatf("value %0d, want %0d", got.value, want.value));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    line_scoreboard sb = new();

    logic [7:0]   line_buf[$];
    logic [127:0] cur_pfx = '0;
    int           cur_len = 0;
    int           burst_left = 0;
    int           items_sent = 0;
    int           cycle_count = 0;
    int           stall_left = 0;
    int           stall_kind = 0;

    reply_line_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 120);
        end
        stall_left--;
        case (stall_kind)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 1) == 1);
            2: i_out_stall <= ($urandom_range(0, 7) == 0);
            default: i_out_stall <= ((stall_left % 6) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_reply(o_out_item);
        end
    end

    task automatic push_item(input logic [1:0] act, input logic [7:0] data);
        t_in_item word;
        int       gap;
        word.action = act;
        word.rx_byte = data;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_item(word);
        items_sent++;
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic configure(input logic [127:0] pfx, input logic [63:0] len_word,
                             input logic [63:0] mode_word);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PREFIX_LOW;
        i_cfg_data <= pfx[63:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_PREFIX_HIGH;
        i_cfg_data <= pfx[127:64];
        @(posedge i_clk);
        i_cfg_index <= CFG_COMPARE_LEN;
        i_cfg_data <= len_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_REPLY_MODE;
        i_cfg_data <= mode_word;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.cfg.prefix_low = pfx[63:0];
        sb.cfg.prefix_high = pfx[127:64];
        sb.cfg.compare_len = len_word[4:0];
        sb.cfg.reply_mode = mode_word[1:0];
        cur_pfx = pfx;
        cur_len = len_word[4:0];
    endtask

    function automatic logic [127:0] pack_text(string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 16; i++) begin
            r[i*8 +: 8] = s[i];
        end
        return r;
    endfunction

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            push_item(ACT_BYTE, s[i]);
        end
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endfunction

    function automatic void add_word();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) line_buf.push_back(8'($urandom_range(97, 122)));
    endfunction

    function automatic void add_number();
        int r;
        int n;
        r = $urandom_range(0, 5);
        if (r == 0) begin
            line_buf.push_back(CHAR_MINUS);
        end else if (r == 1) begin
            line_buf.push_back(CHAR_PLUS);
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            push_text("2147483647");
        end else if (r == 1) begin
            push_text("2147483648");
        end else begin
            n = (r == 2) ? $urandom_range(11, 20) : $urandom_range(0, 4);
            repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0) begin
            add_word();
            line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void build_reply();
        int n;
        int ntok;
        int r;
        line_buf.delete();
        n = (cur_len > 16) ? 16 : cur_len;
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(0, n);
            end
            for (int i = 0; i < n; i++) begin
                line_buf.push_back(cur_pfx[i*8 +: 8]);
            end
            if (n > 0 && $urandom_range(0, 4) == 0) begin
                line_buf[$urandom_range(0, n-1)] ^= 8'($urandom_range(1, 255));
            end
            if (cur_len > 16 && $urandom_range(0, 1) == 0) begin
                line_buf.push_back(CHAR_NUL);
            end
        end else begin
            add_word();
        end
        ntok = $urandom_range(0, 6);
        for (int k = 0; k < ntok; k++) begin
            line_buf.push_back(CHAR_SPACE);
            if ($urandom_range(0, 7) == 0) begin
                line_buf.push_back(CHAR_SPACE);
            end
            r = $urandom_range(0, 9);
            if (r < 6) begin
                add_number();
            end else if (r < 8) begin
                add_word();
            end else if (r == 8) begin
                line_buf.push_back(($urandom_range(0, 1) == 1) ? CHAR_PLUS : CHAR_MINUS);
            end else begin
                line_buf.push_back(CHAR_TAB);
                add_number();
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            line_buf.push_back(CHAR_SPACE);
        end
        if ($urandom_range(0, 11) == 0) begin
            line_buf.insert($urandom_range(0, line_buf.size()), CHAR_NUL);
        end
    endfunction

    task automatic send_reply();
        int kind;
        build_reply();
        kind = $urandom_range(0, 19);
        if (kind == 0 && $urandom_range(0, 3) == 0) begin
            line_buf.delete();
        end
        if (kind == 2) begin
            while (line_buf.size() < LINE_CHARS - 1) begin
                line_buf.push_back(8'($urandom_range(33, 126)));
            end
            line_buf.push_back(8'($urandom_range(0, 255)));
        end
        push_item(ACT_START, 8'($urandom));
        for (int i = 0; i < line_buf.size(); i++) begin
            push_item(ACT_BYTE, line_buf[i]);
        end
        if (kind == 0) begin
            push_item(ACT_TIMEOUT, 8'($urandom));
        end else if (kind > 2) begin
            push_item(ACT_BYTE, LINE_END);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) push_item(2'($urandom_range(0, 3)), 8'($urandom));
    endtask

    function automatic logic [7:0] random_prefix_char();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return CHAR_NUL;
        end
        if (r == 1) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(32, 126));
    endfunction

    initial begin
        logic [127:0] pfx;
        logic [63:0]  len_word;
        logic [63:0]  mode_word;
        int           phase_end;
        int           r;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        configure(pack_text("#VERS"), 64'd2, 64'(MODE_LAST));
        push_item(ACT_TIMEOUT, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_UNUSED, 8'hA5);
        push_item(ACT_START, 8'h5A);
        push_item(ACT_TIMEOUT, 8'h00);
        push_item(ACT_START, 8'h00);
        send_text("#");
        push_item(ACT_TIMEOUT, 8'hFF);
        push_item(ACT_START, 8'hFF);
        send_text("#V");
        push_item(ACT_BYTE, CHAR_NUL);
        send_text("X");
        push_item(ACT_BYTE, LINE_END);
        push_item(ACT_START, 8'h00);
        send_text("#");
        push_item(ACT_BYTE, LINE_END);
        push_item(ACT_START, 8'h00);
        send_text("#V -7");
        push_item(ACT_BYTE, LINE_END);

        // random part, a new setting per phase
        for (int p = 0; p < 9; p++) begin
            drain_replies();
            for (int i = 0; i < 16; i++) begin
                pfx[i*8 +: 8] = random_prefix_char();
            end
            if (p == 1) begin
                pfx = '1;
            end else if (p == 2) begin
                pfx = '0;
            end
            len_word = {$urandom, $urandom};
            mode_word = {$urandom, $urandom};
            case (p)
                0: len_word[4:0] = 5'd0;
                1: len_word[4:0] = 5'd31;
                2: len_word[4:0] = 5'd16;
                default: len_word[4:0] = ($urandom_range(0, 3) == 0) ?
                                         5'($urandom_range(0, 31)) : 5'($urandom_range(1, 8));
            endcase
            if (p < 4) begin
                mode_word[1:0] = 2'(p);
            end else begin
                r = $urandom_range(0, 5);
                if (r == 0) begin
                    mode_word[1:0] = MODE_ECHO;
                end else if (r == 1) begin
                    mode_word[1:0] = MODE_SPARE;
                end else if (r < 4) begin
                    mode_word[1:0] = MODE_LAST;
                end else begin
                    mode_word[1:0] = MODE_FOURTH;
                end
            end
            configure(pfx, len_word, mode_word);
            phase_end = items_sent + 110;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    send_reply();
                end
            end
        end

        drain_replies();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
